@@ hdl/scx_pkg.sv @@
// ----------------------------------------------------------------------------
// scx_pkg
// Shared types, character constants and byte classifiers for the spawn call
// id extractor.
// ----------------------------------------------------------------------------
package scx_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned IdW    = 20;
    localparam int unsigned CountW = 3;

    localparam logic [CountW-1:0] IdDigits = CountW'(6);

    localparam logic [ByteW-1:0] ChS      = 8'h73;  // 's'
    localparam logic [ByteW-1:0] ChP      = 8'h70;  // 'p'
    localparam logic [ByteW-1:0] ChA      = 8'h61;  // 'a'
    localparam logic [ByteW-1:0] ChW      = 8'h77;  // 'w'
    localparam logic [ByteW-1:0] ChN      = 8'h6e;  // 'n'
    localparam logic [ByteW-1:0] ChParen  = 8'h28;  // '('
    localparam logic [ByteW-1:0] ChComma  = 8'h2c;  // ','
    localparam logic [ByteW-1:0] ChSpace  = 8'h20;  // ' '
    localparam logic [ByteW-1:0] ChColon  = 8'h3a;  // ':'
    localparam logic [ByteW-1:0] ChZero   = 8'h30;  // '0'
    localparam logic [ByteW-1:0] ChNine   = 8'h39;  // '9'
    localparam logic [ByteW-1:0] ChLowA   = 8'h61;  // 'a'
    localparam logic [ByteW-1:0] ChLowZ   = 8'h7a;  // 'z'
    localparam logic [ByteW-1:0] ChUpA    = 8'h41;  // 'A'
    localparam logic [ByteW-1:0] ChUpZ    = 8'h5a;  // 'Z'
    localparam logic [ByteW-1:0] ChUnder  = 8'h5f;  // '_'

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_S,
        PH_SP,
        PH_SPA,
        PH_SPAW,
        PH_SPAWN,
        PH_RUN,
        PH_DIG,
        PH_PSP1,
        PH_PCOLON,
        PH_PSP2,
        PH_PDIG
    } t_phase;

    typedef struct packed {
        logic           hit;
        logic [IdW-1:0] found_id;
        logic           second_of_pair;
    } t_result;

    function automatic logic is_dig(input logic [ByteW-1:0] b);
        return (b >= ChZero) && (b <= ChNine);
    endfunction

    function automatic logic is_word(input logic [ByteW-1:0] b);
        return ((b >= ChLowA) && (b <= ChLowZ)) || ((b >= ChUpA) && (b <= ChUpZ))
            || is_dig(b) || (b == ChUnder);
    endfunction

endpackage

@@ hdl/scx_match.sv @@
// ----------------------------------------------------------------------------
// scx_match
// Byte matcher: tracks the call prefix, skip run, digit groups and the
// " : " pair separator, and flags each completed six-digit id.
// ----------------------------------------------------------------------------
module scx_match
    import scx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [ByteW-1:0] i_text_byte,
    input  logic             i_end_of_text,
    output t_result          o_result
);

    t_phase            r_phase,  n_phase;
    logic              r_prior_word;
    logic [IdW-1:0]    r_value,  n_value;
    logic [CountW-1:0] r_count,  n_count;

    logic              fail;
    logic              b_dig;
    logic [IdW-1:0]    acc_value;
    logic [CountW-1:0] acc_count;
    logic [IdW-1:0]    digit;

    assign b_dig     = is_dig(i_text_byte);
    assign digit     = IdW'(i_text_byte - ChZero);
    assign acc_value = (r_value << 3) + (r_value << 1) + digit;
    assign acc_count = r_count + CountW'(1);

    always_comb begin
        n_phase  = r_phase;
        n_value  = r_value;
        n_count  = r_count;
        fail     = 1'b0;
        o_result = '0;
        case (r_phase)
            PH_S: begin
                if (i_text_byte == ChP) n_phase = PH_SP; else fail = 1'b1;
            end
            PH_SP: begin
                if (i_text_byte == ChA) n_phase = PH_SPA;
                else if (i_text_byte == ChParen) n_phase = PH_RUN;
                else fail = 1'b1;
            end
            PH_SPA: begin
                if (i_text_byte == ChW) n_phase = PH_SPAW; else fail = 1'b1;
            end
            PH_SPAW: begin
                if (i_text_byte == ChN) n_phase = PH_SPAWN; else fail = 1'b1;
            end
            PH_SPAWN: begin
                if (i_text_byte == ChParen) n_phase = PH_RUN; else fail = 1'b1;
            end
            PH_RUN: begin
                if (b_dig) begin
                    n_value = digit;
                    n_count = CountW'(1);
                    n_phase = PH_DIG;
                end else if (i_text_byte == ChComma) begin
                    fail = 1'b1;
                end
            end
            PH_DIG, PH_PDIG: begin
                if (b_dig) begin
                    n_value = acc_value;
                    n_count = acc_count;
                    if (acc_count >= IdDigits) begin
                        o_result.hit            = 1'b1;
                        o_result.found_id       = acc_value;
                        o_result.second_of_pair = (r_phase == PH_PDIG);
                        n_phase = (r_phase == PH_PDIG) ? PH_IDLE : PH_PSP1;
                        n_value = '0;
                        n_count = '0;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            PH_PSP1: begin
                if (i_text_byte == ChSpace) n_phase = PH_PCOLON; else fail = 1'b1;
            end
            PH_PCOLON: begin
                if (i_text_byte == ChColon) n_phase = PH_PSP2; else fail = 1'b1;
            end
            PH_PSP2: begin
                if (i_text_byte == ChSpace) begin
                    n_phase = PH_PDIG;
                    n_value = '0;
                    n_count = '0;
                end else begin
                    fail = 1'b1;
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase
        if (fail) begin
            n_value = '0;
            n_count = '0;
            n_phase = (i_text_byte == ChS && !r_prior_word) ? PH_S : PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_prior_word <= 1'b0;
            r_value      <= '0;
            r_count      <= '0;
        end else if (i_take) begin
            if (i_end_of_text) begin
                r_phase      <= PH_IDLE;
                r_prior_word <= 1'b0;
                r_value      <= '0;
                r_count      <= '0;
            end else begin
                r_phase      <= n_phase;
                r_prior_word <= is_word(i_text_byte);
                r_value      <= n_value;
                r_count      <= n_count;
            end
        end
    end

endmodule

@@ hdl/spawn_call_id_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// spawn_call_id_extractor_unit
// Scans text bytes for sp( / spawn( calls and emits the six-digit ids that
// follow, with an optional second id after " : ".
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  input   | i_in_valid / o_in_stall   | i_text_byte, i_end_of_text
//  output  | o_out_valid / i_out_stall | o_found_id, o_second_of_pair
//
//  One byte per cycle unless the input stalls; the matcher decides each
//  byte combinationally. An id goes to the output register when its sixth
//  digit is taken, or to a skid register that holds one id while the output
//  is stalled; the input stalls only while that skid register is full.
//  Reset clears the matcher and the hit flags of both result registers.
// ----------------------------------------------------------------------------
module spawn_call_id_extractor_unit
    import scx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [ByteW-1:0] i_text_byte,
    input  logic             i_end_of_text,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IdW-1:0]   o_found_id,
    output logic             o_second_of_pair
);

    t_result r_out, r_skid;
    t_result result;
    logic    take;
    logic    new_hit;
    logic    out_free;

    assign o_in_stall = r_skid.hit;
    assign take       = i_in_valid && !r_skid.hit;
    assign new_hit    = take && result.hit;
    assign out_free   = !r_out.hit || !i_out_stall;

    scx_match u_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.hit  <= 1'b0;
            r_skid.hit <= 1'b0;
        end else if (out_free) begin
            if (r_skid.hit) begin
                r_out      <= r_skid;
                r_skid.hit <= 1'b0;
            end else if (new_hit) begin
                r_out <= result;
            end else begin
                r_out.hit <= 1'b0;
            end
        end else if (new_hit) begin
            r_skid <= result;
        end
    end

    assign o_out_valid      = r_out.hit;
    assign o_found_id       = r_out.found_id;
    assign o_second_of_pair = r_out.second_of_pair;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams text bytes into spawn_call_id_extractor_unit and compares every id
// it reports against a cycle-free predictor of the call matcher. Directed
// texts come first, then random texts: mostly sp( / spawn( calls with
// random ids, pairs and filler, some of them broken, mixed with noise and
// random end-of-text marks. The sender works in bursts, with one full drain
// mid-run, and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import scx_pkg::*;

    localparam int NumItems  = 1200;
    localparam int LongHold  = 300;
    localparam int QuietMax  = 4000;
    localparam int TailWait  = 8;

    typedef struct {
        logic [IdW-1:0] id;
        logic           second;
    } t_id_rec;

    class t_id_tracker;
        t_phase          phase;
        logic            last_word;
        logic [IdW-1:0]  acc;
        logic [CountW-1:0] cnt;
        t_id_rec         pending_ids[$];
        int              errors;
        int              n_bytes;
        int              n_ids;
        int              n_seconds;
        int              n_texts;

        function new();
            clear();
            errors    = 0;
            n_bytes   = 0;
            n_ids     = 0;
            n_seconds = 0;
            n_texts   = 0;
        endfunction

        function void clear();
            phase     = PH_IDLE;
            last_word = 1'b0;
            acc       = '0;
            cnt       = '0;
        endfunction

        function logic digit_char(logic [ByteW-1:0] b);
            return b >= ChZero && b <= ChNine;
        endfunction

        function logic ident_char(logic [ByteW-1:0] b);
            return (b >= ChLowA && b <= ChLowZ) || (b >= ChUpA && b <= ChUpZ)
                || digit_char(b) || b == ChUnder;
        endfunction

        function void note_byte(logic [ByteW-1:0] b, logic eot);
            logic    prev_word;
            logic    fail;
            t_id_rec rec;
            prev_word = last_word;
            fail      = 1'b0;
            n_bytes++;
            case (phase)
                PH_S: begin
                    if (b == ChP) phase = PH_SP; else fail = 1'b1;
                end
                PH_SP: begin
                    if (b == ChA) phase = PH_SPA;
                    else if (b == ChParen) phase = PH_RUN;
                    else fail = 1'b1;
                end
                PH_SPA: begin
                    if (b == ChW) phase = PH_SPAW; else fail = 1'b1;
                end
                PH_SPAW: begin
                    if (b == ChN) phase = PH_SPAWN; else fail = 1'b1;
                end
                PH_SPAWN: begin
                    if (b == ChParen) phase = PH_RUN; else fail = 1'b1;
                end
                PH_RUN: begin
                    if (digit_char(b)) begin
                        acc   = IdW'(b - ChZero);
                        cnt   = CountW'(1);
                        phase = PH_DIG;
                    end else if (b == ChComma) begin
                        fail = 1'b1;
                    end
                end
                PH_DIG, PH_PDIG: begin
                    if (digit_char(b)) begin
                        acc = IdW'(acc * 10 + (b - ChZero));
                        cnt = cnt + CountW'(1);
                        if (cnt >= IdDigits) begin
                            rec.id     = acc;
                            rec.second = (phase == PH_PDIG);
                            pending_ids.push_back(rec);
                            n_ids++;
                            if (rec.second) n_seconds++;
                            phase = (phase == PH_PDIG) ? PH_IDLE : PH_PSP1;
                            acc   = '0;
                            cnt   = '0;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_PSP1: begin
                    if (b == ChSpace) phase = PH_PCOLON; else fail = 1'b1;
                end
                PH_PCOLON: begin
                    if (b == ChColon) phase = PH_PSP2; else fail = 1'b1;
                end
                PH_PSP2: begin
                    if (b == ChSpace) begin
                        phase = PH_PDIG;
                        acc   = '0;
                        cnt   = '0;
                    end else begin
                        fail = 1'b1;
                    end
                end
                default: fail = 1'b1;
            endcase
            if (fail) begin
                acc   = '0;
                cnt   = '0;
                phase = (b == ChS && !prev_word) ? PH_S : PH_IDLE;
            end
            last_word = ident_char(b);
            if (eot) begin
                clear();
                n_texts++;
            end
        endfunction

        function void check_id(logic [IdW-1:0] id, logic second);
            t_id_rec exp_rec;
            if (pending_ids.size() == 0) begin
                $display("%0t: unexpected id: expected none, actual id %0d second %0b",
                         $time, id, second);
                errors++;
                return;
            end
            exp_rec = pending_ids.pop_front();
            if (id !== exp_rec.id) begin
                $display("%0t: found_id mismatch: expected %0d, actual %0d",
                         $time, exp_rec.id, id);
                errors++;
            end
            if (second !== exp_rec.second) begin
                $display("%0t: second_of_pair mismatch: expected %0b, actual %0b",
                         $time, exp_rec.second, second);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [ByteW-1:0] i_text_byte;
    logic             i_end_of_text;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [IdW-1:0]   o_found_id;
    logic             o_second_of_pair;

    t_id_tracker      sb = new();
    logic [ByteW-1:0] text_q[$];
    int               sent;
    int               burst_left;
    int               quiet;
    logic             hold_req;

    spawn_call_id_extractor_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_text_byte      (i_text_byte),
        .i_end_of_text    (i_end_of_text),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found_id       (o_found_id),
        .o_second_of_pair (o_second_of_pair)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_id(o_found_id, o_second_of_pair);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else if (quiet >= QuietMax) begin
            $display("%0t: no handshake for %0d cycles", $time, QuietMax);
            $display("tb: failure");
            $finish;
        end else begin
            quiet = quiet + 1;
        end
    end

    initial begin
        int mode;
        int mode_left;
        i_out_stall = 1'b0;
        mode        = 0;
        mode_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LongHold - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    function automatic logic [ByteW-1:0] rand_digit();
        case ($urandom_range(0, 9))
            0: return ChZero;
            1: return ChNine;
            default: return ByteW'(ChZero + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [ByteW-1:0] rand_filler();
        logic [ByteW-1:0] b;
        do begin
            b = ($urandom_range(0, 1) == 0) ? ByteW'($urandom_range(32, 126))
                                             : ByteW'($urandom_range(0, 255));
        end while ((b >= ChZero && b <= ChNine) || b == ChComma);
        return b;
    endfunction

    task automatic push_byte(logic [ByteW-1:0] b, logic eot);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(b, eot);
        sent++;
        burst_left--;
    endtask

    task automatic send_str(string s, logic end_text);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], end_text && i == s.len() - 1);
        end
    endtask

    task automatic send_text(logic end_text);
        logic eot;
        for (int i = 0; i < text_q.size(); i++) begin
            eot = (end_text && i == text_q.size() - 1) || $urandom_range(0, 99) == 0;
            push_byte(text_q[i], eot);
        end
    endtask

    task automatic add_call(logic clean);
        int start;
        int pos;
        start = text_q.size();
        case ($urandom_range(0, 4))
            0: ;
            1: text_q.push_back(ChSpace);
            2: text_q.push_back(ChUnder);
            3: text_q.push_back(ByteW'(ChLowA + $urandom_range(0, 25)));
            default: text_q.push_back(ByteW'($urandom_range(0, 255)));
        endcase
        text_q.push_back(ChS);
        text_q.push_back(ChP);
        if ($urandom_range(0, 1) == 0) begin
            text_q.push_back(ChA);
            text_q.push_back(ChW);
            text_q.push_back(ChN);
        end
        text_q.push_back(ChParen);
        repeat ($urandom_range(0, 3)) text_q.push_back(rand_filler());
        repeat (6) text_q.push_back(rand_digit());
        if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(rand_digit());
        end else if ($urandom_range(0, 1) == 0) begin
            text_q.push_back(ChSpace);
            text_q.push_back(ChColon);
            text_q.push_back(ChSpace);
            repeat (6) text_q.push_back(rand_digit());
        end
        if (!clean) begin
            pos = $urandom_range(start, text_q.size() - 1);
            case ($urandom_range(0, 2))
                0: text_q[pos] = ByteW'($urandom_range(0, 255));
                1: text_q.insert(pos, ChComma);
                default: while (text_q.size() > pos) void'(text_q.pop_back());
            endcase
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
                0: text_q.push_back(ChS);
                1: text_q.push_back(ChP);
                2: text_q.push_back(ChParen);
                default: text_q.push_back(ByteW'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_ids.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int   k;
        logic held;
        logic drained;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_text_byte   = '0;
        i_end_of_text = 1'b0;
        hold_req      = 1'b0;
        sent          = 0;
        burst_left    = 0;
        quiet         = 0;
        held          = 1'b0;
        drained       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_str("sp(999999 : 000000", 1'b1);
        send_str("spawn(-0123456", 1'b0);
        push_byte(8'hff, 1'b1);

        while (sent < NumItems) begin
            text_q.delete();
            k = $urandom_range(0, 9);
            if (k < 5) add_call(1'b1);
            else if (k < 8) add_call(1'b0);
            else add_noise();
            send_text($urandom_range(0, 3) == 0);

            if (!held && sent >= 400) begin
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (12) begin
                    text_q.delete();
                    add_call(1'b1);
                    burst_left = 1000;
                    send_text(1'b0);
                end
                burst_left = 0;
            end
            if (!drained && sent >= 800) begin
                drained = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (TailWait) @(posedge i_clk);
        $display("tb: %0d bytes in %0d ended texts, %0d ids reported",
                 sb.n_bytes, sb.n_texts, sb.n_ids);
        $display("tb: %0d of those ids were the second of a pair", sb.n_seconds);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
